// ===== rtl/core/fcd_pkg.sv =====
// shared constants, codes and control types of the fault confirmation debouncer
package fcd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_BITS      = 64;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int STREAK_W = 8;
  localparam int REPEAT_W = 32;
  localparam int FRESH_W  = 7;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 31;

  // key table word: key, reported flag, repeat count
  localparam int KA_W = KEY_BITS + 1 + REPEAT_W;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(30000);
  localparam logic [STREAK_W-1:0] CONFIRM_RESET = STREAK_W'(3);
  localparam logic [FRESH_W-1:0]  CAP_RESET     = FRESH_W'(8);

  typedef enum logic [1:0] {
    FUNC_POLL = 2'd0,
    FUNC_FAIL = 2'd1,
    FUNC_END  = 2'd2
  } fcd_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_PERIOD  = 2'd1,
    CFG_CONFIRM = 2'd2,
    CFG_CAP     = 2'd3
  } fcd_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_WALK,
    ST_EMIT
  } fcd_state_t;

  // result word, run_due in bit 0
  typedef struct packed {
    logic [FRESH_W-1:0]  fresh_total;
    logic [REPEAT_W-1:0] repeat_count;
    logic [STREAK_W-1:0] streak_now;
    logic                not_in_run;
    logic                table_full;
    logic                dropped_over_cap;
    logic                report_new;
    logic                run_due;
  } fcd_res_t;

  typedef struct packed {
    logic capture;
    logic do_poll;
    logic not_in_run;
    logic lk_start;
    logic lk_step;
    logic do_update;
    logic walk_start;
    logic walk_step;
    logic do_end;
    logic load_out;
  } fcd_cmd_t;

  typedef struct packed {
    fcd_func_t func;
    logic      run_open;
    logic      lk_hit;
    logic      lk_miss;
    logic      walk_done;
    logic      out_free;
  } fcd_sts_t;

endpackage

// ===== rtl/core/fcd_ram.sv =====
// generic single-write, single-read ram with registered read data
module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fcd_ctrl.sv =====
// sequencing state machine of the fault confirmation debouncer
module fcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  fcd_pkg::fcd_sts_t sts,
  output fcd_pkg::fcd_cmd_t cmd
);

  fcd_pkg::fcd_state_t state_r;
  fcd_pkg::fcd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      fcd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = fcd_pkg::ST_DECODE;
        end
      end
      fcd_pkg::ST_DECODE: begin
        state_nxt = fcd_pkg::ST_EMIT;
        case (sts.func)
          fcd_pkg::FUNC_POLL: begin
            cmd.do_poll = 1'b1;
          end
          fcd_pkg::FUNC_FAIL: begin
            if (!sts.run_open) begin
              cmd.not_in_run = 1'b1;
            end else begin
              cmd.lk_start = 1'b1;
              state_nxt    = fcd_pkg::ST_LOOKUP;
            end
          end
          fcd_pkg::FUNC_END: begin
            if (!sts.run_open) begin
              cmd.not_in_run = 1'b1;
            end else begin
              cmd.walk_start = 1'b1;
              state_nxt      = fcd_pkg::ST_WALK;
            end
          end
          default: begin
            state_nxt = fcd_pkg::ST_EMIT;
          end
        endcase
      end
      fcd_pkg::ST_LOOKUP: begin
        cmd.lk_step = 1'b1;
        if (sts.lk_hit || sts.lk_miss) begin
          state_nxt = fcd_pkg::ST_UPDATE;
        end
      end
      fcd_pkg::ST_UPDATE: begin
        cmd.do_update = 1'b1;
        state_nxt     = fcd_pkg::ST_EMIT;
      end
      fcd_pkg::ST_WALK: begin
        if (sts.walk_done) begin
          cmd.do_end = 1'b1;
          state_nxt  = fcd_pkg::ST_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      fcd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = fcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fcd_dp.sv =====
// datapath: registers, key table, streak walk and result register
module fcd_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fcd_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fcd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  fcd_pkg::fcd_cmd_t                cmd,
  output fcd_pkg::fcd_sts_t                sts
);

  localparam int IDX_W = fcd_pkg::IDX_W;
  localparam int CNT_W = fcd_pkg::CNT_W;
  localparam int KB    = fcd_pkg::KEY_BITS;
  localparam int RW    = fcd_pkg::REPEAT_W;
  localparam int SW    = fcd_pkg::STREAK_W;
  localparam int FW    = fcd_pkg::FRESH_W;
  // streak table word: failed-in-this-run flag above the streak
  localparam int STW   = SW + 1;

  // configuration
  logic                          enable_r;
  logic [fcd_pkg::PERIOD_W-1:0]  period_r;
  logic [SW-1:0]                 confirm_r;
  logic [FW-1:0]                 cap_r;

  // run state
  logic [fcd_pkg::TIME_W-1:0]    next_due_r;
  logic                          have_run_r;
  logic                          run_open_r;
  logic [FW-1:0]                 fresh_r;
  logic [CNT_W-1:0]              used_r;

  // captured item
  fcd_pkg::fcd_func_t            func_r;
  logic [fcd_pkg::TIME_W-1:0]    now_r;
  logic [KB-1:0]                 key_r;

  // scan and selected entry
  logic [CNT_W-1:0]              scan_r;
  logic                          pend_vld_r;
  logic [IDX_W-1:0]              pend_idx_r;
  logic [IDX_W-1:0]              sel_idx_r;
  logic                          sel_new_r;
  logic                          sel_full_r;
  logic [SW-1:0]                 old_streak_r;
  logic                          old_rep_r;
  logic [RW-1:0]                 old_repeats_r;

  fcd_pkg::fcd_res_t             res_r;
  fcd_pkg::fcd_res_t             out_res_r;
  logic                          out_valid_r;

  // table ports
  logic                          ka_we;
  logic [fcd_pkg::KA_W-1:0]      ka_wdata;
  logic [fcd_pkg::KA_W-1:0]      ka_rdata;
  logic                          st_we;
  logic [IDX_W-1:0]              st_waddr;
  logic [STW-1:0]                st_wdata;
  logic [STW-1:0]                st_rdata;

  logic [IDX_W-1:0]              scan_idx;
  logic                          scan_lt_used;
  logic                          scan_done;
  logic                          lk_hit;
  logic                          lk_miss;
  logic [SW-1:0]                 walk_streak;
  logic [fcd_pkg::TIME_W-1:0]    since_due;
  logic                          due;
  logic [SW-1:0]                 new_streak;
  logic [RW-1:0]                 new_repeats;
  logic                          new_rep;
  logic                          confirm_now;
  logic                          under_cap;

  assign cfg_ready    = 1'b1;
  assign scan_idx     = scan_r[IDX_W-1:0];
  assign scan_lt_used = scan_r < used_r;
  // every used entry has been read and handled
  assign scan_done    = !pend_vld_r && !scan_lt_used;
  assign lk_hit       = pend_vld_r && (ka_rdata[KB-1:0] == key_r);
  assign lk_miss      = scan_done;

  assign since_due = now_r - next_due_r;
  assign due       = enable_r && !run_open_r && (!have_run_r || !since_due[fcd_pkg::TIME_W-1]);

  // entry update for a failure
  always_comb begin
    new_streak  = (old_streak_r == '1) ? old_streak_r : old_streak_r + SW'(1);
    new_repeats = old_repeats_r;
    new_rep     = old_rep_r;
    confirm_now = 1'b0;
    under_cap   = fresh_r < cap_r;
    if (old_rep_r) begin
      if (old_repeats_r != '1) begin
        new_repeats = old_repeats_r + RW'(1);
      end
    end else if (new_streak >= confirm_r) begin
      new_rep     = 1'b1;
      confirm_now = 1'b1;
    end
  end

  // walk keeps the streak of an entry that failed in the run, zeroes the rest,
  // and clears the flag for the next run
  assign walk_streak = st_rdata[SW] ? st_rdata[SW-1:0] : '0;

  assign ka_we    = cmd.do_update && !sel_full_r;
  assign ka_wdata = {new_repeats, new_rep, key_r};
  assign st_we    = ka_we || (cmd.walk_step && pend_vld_r);
  assign st_waddr = cmd.do_update ? sel_idx_r : pend_idx_r;
  assign st_wdata = cmd.do_update ? {1'b1, new_streak} : {1'b0, walk_streak};

  fcd_ram #(
    .WIDTH (fcd_pkg::KA_W),
    .DEPTH (fcd_pkg::TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ka_we),
    .waddr (sel_idx_r),
    .wdata (ka_wdata),
    .raddr (scan_idx),
    .rdata (ka_rdata)
  );

  fcd_ram #(
    .WIDTH (STW),
    .DEPTH (fcd_pkg::TABLE_ENTRIES)
  ) u_streak_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (scan_idx),
    .rdata (st_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      period_r  <= fcd_pkg::PERIOD_RESET;
      confirm_r <= fcd_pkg::CONFIRM_RESET;
      cap_r     <= fcd_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      case (fcd_pkg::fcd_cfg_idx_t'(cfg_index))
        fcd_pkg::CFG_ENABLE:  enable_r  <= cfg_data[0];
        fcd_pkg::CFG_PERIOD:  period_r  <= cfg_data[fcd_pkg::PERIOD_W-1:0];
        fcd_pkg::CFG_CONFIRM: confirm_r <= cfg_data[SW-1:0];
        fcd_pkg::CFG_CAP:     cap_r     <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  // run control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_due_r <= '0;
      have_run_r <= 1'b0;
      run_open_r <= 1'b0;
      fresh_r    <= '0;
      used_r     <= '0;
    end else begin
      if (cmd.do_poll && due) begin
        next_due_r <= now_r + {1'b0, period_r};
        have_run_r <= 1'b1;
        run_open_r <= 1'b1;
        fresh_r    <= '0;
      end
      if (cmd.do_update && !sel_full_r) begin
        if (sel_new_r) begin
          used_r <= used_r + CNT_W'(1);
        end
        if (confirm_now && under_cap) begin
          fresh_r <= fresh_r + FW'(1);
        end
      end
      if (cmd.do_end) begin
        run_open_r <= 1'b0;
      end
    end
  end

  // item capture, scan and result building
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= fcd_pkg::fcd_func_t'(in_tuser);
      now_r  <= in_tdata[fcd_pkg::TIME_W-1:0];
      key_r  <= in_tdata[fcd_pkg::TIME_W +: KB];
      res_r  <= '0;
    end
    if (cmd.lk_start || cmd.walk_start) begin
      scan_r     <= '0;
      pend_vld_r <= 1'b0;
    end
    if (cmd.lk_step || cmd.walk_step) begin
      scan_r     <= scan_r + CNT_W'(scan_lt_used);
      pend_vld_r <= scan_lt_used;
      pend_idx_r <= scan_idx;
    end
    if (cmd.lk_step) begin
      if (lk_hit) begin
        sel_idx_r     <= pend_idx_r;
        sel_new_r     <= 1'b0;
        sel_full_r    <= 1'b0;
        old_streak_r  <= st_rdata[SW-1:0];
        old_rep_r     <= ka_rdata[KB];
        old_repeats_r <= ka_rdata[KB+1 +: RW];
      end else if (lk_miss) begin
        sel_idx_r     <= used_r[IDX_W-1:0];
        sel_new_r     <= 1'b1;
        sel_full_r    <= used_r == CNT_W'(fcd_pkg::TABLE_ENTRIES);
        old_streak_r  <= '0;
        old_rep_r     <= 1'b0;
        old_repeats_r <= '0;
      end
    end
    if (cmd.do_poll) begin
      res_r.run_due <= due;
    end
    if (cmd.not_in_run) begin
      res_r.not_in_run <= 1'b1;
    end
    if (cmd.do_update) begin
      if (sel_full_r) begin
        res_r.table_full <= 1'b1;
      end else begin
        res_r.streak_now       <= new_streak;
        res_r.repeat_count     <= new_repeats;
        res_r.report_new       <= confirm_now && under_cap;
        res_r.dropped_over_cap <= confirm_now && !under_cap;
      end
    end
    if (cmd.do_end) begin
      res_r.fresh_total <= fresh_r;
    end
    if (cmd.load_out) begin
      out_res_r <= res_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(fcd_pkg::OUT_DATA_W - $bits(fcd_pkg::fcd_res_t))'(0), out_res_r};

  assign sts.func      = func_r;
  assign sts.run_open  = run_open_r;
  assign sts.lk_hit    = lk_hit;
  assign sts.lk_miss   = lk_miss;
  assign sts.walk_done = scan_done;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

// ===== rtl/core/fault_confirmation_debouncer.sv =====
// top level of the fault confirmation debouncer
//
// Confirms checks that keep failing over consecutive runs of a periodic watcher.
// A poll transfer (tuser 0) opens a run when enabled, no run is open and the wrap-safe
// deadline has passed; a failure transfer (tuser 1) looks up or inserts its key in a
// 64-entry table and bumps its streak, marking it reported at confirm_count and
// emitting it while the run's report cap allows; an end transfer (tuser 2)
// closes the run and zeroes the streak of every key that did not fail in it.
// Every input transfer gives exactly one result transfer. Items are handled one
// at a time: the key lookup of a failure reads the table ram one entry per cycle,
// and the streak walk of an end item reads and rewrites one entry per cycle.
// The failed-in-this-run flag of each entry sits beside its streak and the
// end-of-run walk clears it, so every run starts with all flags clear.
// The output register lets a new item be taken while a result waits.
// Configuration writes are always taken and must only be made while idle.
module fault_confirmation_debouncer (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcd_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fcd_pkg::IN_DATA_W-1:0]  in_tdata,  // now_ms[31:0], check_key[95:32]
  input  logic [1:0]                     in_tuser,  // func[1:0]
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // run_due[0], report_new[1], dropped_over_cap[2], table_full[3], not_in_run[4],
  // streak_now[12:5], repeat_count[44:13], fresh_total[51:45], zero[55:52]
  output logic [fcd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // commands from the sequencer, status back from the datapath
  fcd_pkg::fcd_cmd_t cmd;
  fcd_pkg::fcd_sts_t sts;

  fcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/core/fcd_chk.sv =====
// port-level checker of the fault confirmation debouncer, bound to the top level
module fcd_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fcd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // at most one outcome flag per failure or end result
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[4:1]))
    else $error("conflicting outcome flags");

  // a new report needs a nonzero streak
  a_report_streak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[12:5] != 8'd0)
    else $error("report with zero streak");

  // each report is a distinct table entry
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[51:45] <= 7'(fcd_pkg::TABLE_ENTRIES))
    else $error("more reports than table entries");

endmodule

bind fault_confirmation_debouncer fcd_chk u_fcd_chk (.*);
